// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication: when cond holds, prop holds in the next cycle.
`define SMC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/smc_pkg.sv =====
// Types and constants for the steered media clock.
// No dependencies; used by every other file of the block but assert_macros.svh.
package smc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_RESET  = 2'd1,
        MODE_RESUME = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_CHUNK = 2'd0,
        CFG_SEEK  = 2'd1,
        CFG_BACK  = 2'd2,
        CFG_STALL = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0]  CHUNK_RST    = 10'd46;
    localparam logic [15:0] SEEK_RST     = 16'd2000;
    localparam logic [15:0] BACK_RST     = 16'd500;
    localparam logic [15:0] STALL_RST    = 16'd300;
    localparam logic [31:0] NO_LENGTH_MS = 32'd3600000;

    typedef struct packed {
        logic [9:0]  chunk_ms;
        logic [15:0] seek_margin_ms;
        logic [15:0] back_margin_ms;
        logic [15:0] stall_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] carried_tick;
        logic [31:0] position;
        logic [31:0] last_report;
        logic [31:0] last_report_tick;
    } t_state;

    // accepted beat plus terms worked out on the way in
    typedef struct packed {
        t_mode       mode;
        logic [31:0] now_tick;
        logic [31:0] report_pos_ms;
        logic [31:0] track_length_ms;
        logic        playing;
        logic        paused;
        logic [31:0] elapsed;
        logic [31:0] since;
        logic [31:0] middle;
    } t_item;

    typedef struct packed {
        logic        running;
        logic [31:0] position_ms;
        logic [31:0] position_now_ms;
        logic [31:0] remaining_ms;
        logic        report_stalled;
    } t_result;

endpackage

// ===== hdl/smc_if.sv =====
// Handshake channel interfaces: input items, result items, register writes.
// Depends on smc_pkg for the register port widths.
interface smc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] now_tick;
    logic [31:0] report_pos_ms;
    logic [31:0] track_length_ms;
    logic        playing;
    logic        paused;

    modport source (output valid, mode, now_tick, report_pos_ms, track_length_ms,
                    playing, paused, input ready);
    modport sink (input valid, mode, now_tick, report_pos_ms, track_length_ms,
                  playing, paused, output ready);
endinterface

interface smc_out_if;
    logic        valid;
    logic        ready;
    logic        running;
    logic [31:0] position_ms;
    logic [31:0] position_now_ms;
    logic [31:0] remaining_ms;
    logic        report_stalled;

    modport source (output valid, running, position_ms, position_now_ms, remaining_ms,
                    report_stalled, input ready);
    modport sink (input valid, running, position_ms, position_now_ms, remaining_ms,
                  report_stalled, output ready);
endinterface

interface smc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [smc_pkg::CFG_IDX_W-1:0]    index;
    logic [smc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/smc_step.sv =====
// One clock update: next state and result for a registered item.
// Depends on smc_pkg.
module smc_step (
    input  smc_pkg::t_item   i_item,
    input  smc_pkg::t_state  i_state,
    input  smc_pkg::t_cfg    i_cfg,
    output smc_pkg::t_state  o_next,
    output smc_pkg::t_result o_res
);

    logic        changed;
    logic        disc;
    logic        stall;
    logic        running;
    logic        stalled;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] slack;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] since_eff;
    logic [31:0] pos;
    logic signed [31:0] err;
    logic signed [31:0] q;

    assign changed   = i_item.report_pos_ms != i_state.last_report;
    assign disc      = changed &&
                       ((i_item.report_pos_ms + 32'(i_cfg.back_margin_ms) < i_state.last_report) ||
                        (i_item.report_pos_ms > i_state.last_report + i_item.elapsed +
                                                32'(i_cfg.seek_margin_ms)));
    assign since_eff = changed ? 32'd0 : i_item.since;
    assign stall     = i_item.playing && !i_item.paused &&
                       ($signed(since_eff) > $signed(32'(i_cfg.stall_ms)));

    assign p1    = i_state.position + i_item.elapsed;
    assign err   = $signed(i_item.middle - p1);
    assign q     = (err + (err[31] ? 32'sd7 : 32'sd0)) >>> 3;
    assign p2    = p1 + q;
    assign slack = 32'(i_cfg.chunk_ms) + i_item.elapsed;
    assign lo    = i_item.middle - slack;
    assign hi    = i_item.middle + slack;

    always_comb begin
        pos     = i_state.position;
        running = 1'b1;
        stalled = 1'b0;
        case (i_item.mode)
            smc_pkg::MODE_TICK: begin
                if (disc) begin
                    pos     = i_item.middle;
                    running = 1'b0;
                end else if (stall) begin
                    pos     = p1;
                    stalled = 1'b1;
                end else if ($signed(p2) < $signed(lo)) begin
                    pos = lo;
                end else if ($signed(p2) > $signed(hi)) begin
                    pos = hi;
                end else begin
                    pos = p2;
                end
            end
            smc_pkg::MODE_RESET: begin
                pos = i_item.middle;
            end
            default: begin
                pos = i_state.position;
            end
        endcase
    end

    always_comb begin
        o_next.position = pos;
        if (i_item.mode == smc_pkg::MODE_QUERY) begin
            o_next.carried_tick     = i_state.carried_tick;
            o_next.last_report      = i_state.last_report;
            o_next.last_report_tick = i_state.last_report_tick;
        end else begin
            o_next.carried_tick     = i_item.now_tick;
            o_next.last_report      = i_item.report_pos_ms;
            o_next.last_report_tick = (i_item.mode != smc_pkg::MODE_TICK || changed) ?
                                      i_item.now_tick : i_state.last_report_tick;
        end
    end

    // carried tick moves to now except on a query
    assign o_res.running         = running;
    assign o_res.report_stalled  = stalled;
    assign o_res.position_ms     = pos;
    assign o_res.position_now_ms = pos +
                                   ((i_item.mode == smc_pkg::MODE_QUERY) ? i_item.elapsed : 32'd0);
    assign o_res.remaining_ms    = (i_item.track_length_ms == 32'd0) ? smc_pkg::NO_LENGTH_MS :
                                   (i_item.track_length_ms > pos) ?
                                   (i_item.track_length_ms - pos) : 32'd0;

endmodule

// ===== hdl/steered_media_clock.sv =====
// Steered media clock top level: input register, step logic, result register.
// Depends on smc_pkg, smc_if.sv, smc_step and assert_macros.svh.
//
// Usage:
//   i_in  : items (mode, now_tick, report_pos_ms, track_length_ms, playing, paused).
//           A beat moves when valid and ready are both high.
//   o_out : one result beat per item (running, position_ms, position_now_ms,
//           remaining_ms, report_stalled), in item order.
//   i_cfg : register writes, index 0 chunk_ms, 1 seek_margin_ms, 2 back_margin_ms,
//           3 stall_ms. Ready out of reset; write only while no item is in flight.
//   Path: an accepted item sits in the input register, then in the result register.
//   Throughput: one item per cycle while the output is not stalled. The state update
//   for an item is done in one pass of the step logic; elapsed and since terms are
//   formed on the way in from the forwarded state of the item ahead.
//   Stall: the result register holds while o_out.ready is low; one more item is
//   still taken into the input register, then i_in.ready drops.
//   Reset (i_rst_n low, synchronous): state cleared to zero, registers back to
//   chunk 46, seek 2000, back 500, stall 300 ms; no beats in flight, ready low.
`include "assert_macros.svh"

module steered_media_clock #(
    parameter int TICK_HZ = 100
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smc_in_if.sink        i_in,
    smc_out_if.source     o_out,
    smc_cfg_if.sink       i_cfg
);

    localparam logic [31:0] MS_PER_TICK = 32'(1000 / TICK_HZ);

    logic             r_s1_valid;
    smc_pkg::t_item   r_s1;
    smc_pkg::t_item   n_s1;
    logic             r_out_valid;
    smc_pkg::t_result r_out;
    smc_pkg::t_state  r_state;
    smc_pkg::t_cfg    r_cfg;

    smc_pkg::t_state  step_next;
    smc_pkg::t_result step_res;
    smc_pkg::t_state  fwd;
    logic             s1_adv;
    logic             in_accept;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;

    assign fwd = s1_adv ? step_next : r_state;

    always_comb begin
        n_s1.mode            = smc_pkg::t_mode'(i_in.mode);
        n_s1.now_tick        = i_in.now_tick;
        n_s1.report_pos_ms   = i_in.report_pos_ms;
        n_s1.track_length_ms = i_in.track_length_ms;
        n_s1.playing         = i_in.playing;
        n_s1.paused          = i_in.paused;
        n_s1.elapsed         = 32'((i_in.now_tick - fwd.carried_tick) * MS_PER_TICK);
        n_s1.since           = 32'((i_in.now_tick - fwd.last_report_tick) * MS_PER_TICK);
        n_s1.middle          = i_in.report_pos_ms + 32'(r_cfg.chunk_ms[9:1]);
    end

    smc_step u_step (
        .i_item  (r_s1),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_next  (step_next),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_cfg.chunk_ms       <= smc_pkg::CHUNK_RST;
            r_cfg.seek_margin_ms <= smc_pkg::SEEK_RST;
            r_cfg.back_margin_ms <= smc_pkg::BACK_RST;
            r_cfg.stall_ms       <= smc_pkg::STALL_RST;
        end else begin
            r_s1_valid  <= in_accept || (r_s1_valid && !s1_adv);
            r_out_valid <= s1_adv || (r_out_valid && !o_out.ready);
            if (s1_adv) begin
                r_state <= step_next;
            end
            if (i_cfg.valid) begin
                case (smc_pkg::t_cfg_idx'(i_cfg.index))
                    smc_pkg::CFG_CHUNK: r_cfg.chunk_ms       <= i_cfg.data[9:0];
                    smc_pkg::CFG_SEEK:  r_cfg.seek_margin_ms <= i_cfg.data;
                    smc_pkg::CFG_BACK:  r_cfg.back_margin_ms <= i_cfg.data;
                    smc_pkg::CFG_STALL: r_cfg.stall_ms       <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.running         = r_out.running;
    assign o_out.position_ms     = r_out.position_ms;
    assign o_out.position_now_ms = r_out.position_now_ms;
    assign o_out.remaining_ms    = r_out.remaining_ms;
    assign o_out.report_stalled  = r_out.report_stalled;

    `SMC_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, in_accept, r_s1_valid, "accepted beat lost")
    `SMC_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_out.ready, r_s1_valid, "held item dropped")
    `SMC_ASSERT_NEXT(a_query_keeps, i_clk, i_rst_n, s1_adv && r_s1.mode == smc_pkg::MODE_QUERY, $stable(r_state.carried_tick), "query moved tick")
    `SMC_ASSERT(a_stall_running, i_clk, i_rst_n, !(o_out.valid && o_out.report_stalled && !o_out.running), "stalled reseed")

endmodule
